>>> rtl/amck_pkg.sv
`default_nettype none

package amck_pkg;

    // Field and register widths
    localparam int SAMPLE_W    = 16;
    localparam int VOL_W       = 7;
    localparam int FRAME_W     = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;

    // Gain register limits
    localparam int VOL_MAX   = 100;
    localparam int VOL_RESET = 100;

    // Click length default
    localparam int CLICK_FRAMES_DEF = 180;

    // Divisors of the two arithmetic lanes
    localparam int AMB_DIV   = 100;
    localparam int NOISE_DIV = 30;

    // Pseudo-noise phase: (f * NOISE_MUL) mod NOISE_MOD, centered by NOISE_OFS
    localparam int NOISE_MUL  = 37;
    localparam int NOISE_MOD  = 23;
    localparam int NOISE_OFS  = 11;
    localparam int PH_W       = 6;
    localparam int NOISE_STEP = NOISE_MUL % NOISE_MOD;

    // Click weight: env/2 * K / NOISE_DIV gives the click magnitude
    localparam int K_W    = 6;
    localparam int SLOW_K = 2 * NOISE_DIV;
    localparam int FAST_K = NOISE_DIV;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_VOLUME    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_SOUND = CFG_INDEX_W'(1);

    // Click types
    typedef enum logic [1:0] {
        KS_OFF   = 2'd0,
        KS_NOISE = 2'd1,
        KS_SLOW  = 2'd2,
        KS_FAST  = 2'd3
    } key_sound_t;

endpackage

`default_nettype wire

>>> rtl/ambient_mix_with_key_click_unit.sv
`default_nettype none

// Ambient mixer with key click. Each input transfer carries one mono ambient
// sample plus flags; the block scales the ambient by volume/100, adds the
// active click (pseudo-noise, slow square or fast square, fading linearly
// over CLICK_FRAMES frames), saturates to 16 bits and sends one result
// transfer, or none when ambience is off and no click is running. A frame
// that yields a result is accepted, then runs in the bit-serial lanes
// (7 multiply steps over the volume bits, then 23 divide steps for
// the ambient product / 100, which is the longer lane), then loads the
// output register. A frame without result does not start the lanes. The next frame
// is accepted while a result still waits in the output register.
// Configuration writes (0: volume, low 7 bits clamped to 100; 1: key sound) are always
// taken; write them only while the block is idle.
module ambient_mix_with_key_click_unit #(
    parameter int CLICK_FRAMES = amck_pkg::CLICK_FRAMES_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // Input stream
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [amck_pkg::SAMPLE_W-1:0]         s_tdata,  // [15:0] ambient_sample
    input  wire logic [1:0]                            s_tuser,  // [0] ambient_valid, [1] key_trigger
    // Result stream
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [amck_pkg::SAMPLE_W-1:0]              m_tdata,  // [15:0] mixed_sample
    output logic                                       m_tuser,  // [0] clipped
    // Configuration writes
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [amck_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [amck_pkg::CFG_DATA_W-1:0]       cfg_data
);

    import amck_pkg::*;

    localparam int AW_A = SAMPLE_W;
    localparam int AW_B = FRAME_W + K_W;
    localparam int QW   = SAMPLE_W + 1;
    localparam int SW   = SAMPLE_W + 3;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_WAIT = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [VOL_W-1:0]      volume_reg, volume_next;
    key_sound_t            key_sound_reg, key_sound_next;
    logic [FRAME_W-1:0]    click_frame_reg, click_frame_next;
    logic [PH_W-1:0]       phase_reg, phase_next;
    logic                  amb_neg_reg, amb_neg_next;
    logic                  clk_neg_reg, clk_neg_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_W-1:0]   mixed_reg, mixed_next;
    logic                  clip_reg, clip_next;

    logic                  in_xfer;
    logic                  trig_go;
    logic [FRAME_W-1:0]    f_eff;
    logic [PH_W-1:0]       p_eff;
    logic                  has_res;
    logic [AW_A-1:0]       amb_mag;
    logic                  amb_neg;
    logic [FRAME_W-1:0]    frames_left;
    logic [PH_W-1:0]       ph_mag;
    logic [K_W-1:0]        click_k;
    logic                  clk_neg;
    logic [AW_B-1:0]       click_a;
    logic [FRAME_W:0]      f_inc;
    logic [PH_W-1:0]       p_inc;
    logic [VOL_W-1:0]      vol_wr;

    logic                  lane_start;
    logic                  a_idle, b_idle;
    logic [AW_A+VOL_W-1:0] a_q;
    logic [AW_B+VOL_W-1:0] b_q;
    logic                  slot_free;
    logic                  out_load;
    logic signed [SW-1:0]  amb_s, clk_s, sum_s;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = s_tvalid && s_tready;

    // Trigger handling ahead of the mix
    assign trig_go = s_tuser[1] && (key_sound_reg != KS_OFF);
    assign f_eff   = trig_go ? FRAME_W'(1) : click_frame_reg;
    assign p_eff   = trig_go ? PH_W'(NOISE_STEP) : phase_reg;
    assign has_res = s_tuser[0] || (f_eff != '0);

    // Ambient magnitude and sign
    assign amb_neg = s_tuser[0] && s_tdata[SAMPLE_W-1];
    always_comb begin
        if (!s_tuser[0]) begin
            amb_mag = '0;
        end else if (s_tdata[SAMPLE_W-1]) begin
            amb_mag = ~s_tdata + AW_A'(1);
        end else begin
            amb_mag = s_tdata;
        end
    end

    // Click operand: (frames left) * weight, sign per click type
    assign frames_left = FRAME_W'(CLICK_FRAMES) - f_eff;
    assign ph_mag = (p_eff >= PH_W'(NOISE_OFS)) ? (p_eff - PH_W'(NOISE_OFS))
                                                 : (PH_W'(NOISE_OFS) - p_eff);
    always_comb begin
        click_k = '0;
        clk_neg = 1'b0;
        case (key_sound_reg)
            KS_NOISE: begin
                click_k = K_W'({ph_mag, 1'b0});
                clk_neg = (p_eff < PH_W'(NOISE_OFS));
            end
            KS_SLOW: begin
                click_k = K_W'(SLOW_K);
                clk_neg = f_eff[2];
            end
            KS_FAST: begin
                click_k = K_W'(FAST_K);
                clk_neg = f_eff[1];
            end
            default: begin
                click_k = '0;
                clk_neg = 1'b0;
            end
        endcase
        if (f_eff == '0) begin
            click_k = '0;
        end
    end
    assign click_a = AW_B'(frames_left) * AW_B'(click_k);

    // Frame counter and noise phase advance
    assign f_inc = {1'b0, f_eff} + (FRAME_W+1)'(1);
    always_comb begin
        p_inc = p_eff + PH_W'(NOISE_STEP);
        if (p_inc >= PH_W'(NOISE_MOD)) begin
            p_inc = p_inc - PH_W'(NOISE_MOD);
        end
    end

    // Configuration
    assign vol_wr = (cfg_data[VOL_W-1:0] > VOL_W'(VOL_MAX)) ? VOL_W'(VOL_MAX)
                                                             : cfg_data[VOL_W-1:0];

    assign lane_start = in_xfer && has_res;

    amck_serial_md #(
        .AW  (AW_A),
        .BW  (VOL_W),
        .DIV (AMB_DIV)
    ) u_amb_lane (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (lane_start),
        .a_in    (amb_mag),
        .b_in    (volume_reg),
        .idle    (a_idle),
        .q       (a_q)
    );

    amck_serial_md #(
        .AW  (AW_B),
        .BW  (VOL_W),
        .DIV (NOISE_DIV)
    ) u_click_lane (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (lane_start),
        .a_in    (click_a),
        .b_in    (volume_reg),
        .idle    (b_idle),
        .q       (b_q)
    );

    // Signed mix and saturation
    assign amb_s = amb_neg_reg ? -SW'(a_q[QW-1:0]) : SW'(a_q[QW-1:0]);
    assign clk_s = clk_neg_reg ? -SW'(b_q[QW-1:0]) : SW'(b_q[QW-1:0]);
    assign sum_s = amb_s + clk_s;

    assign slot_free = !m_tvalid_reg || m_tready;
    assign out_load  = ((state_reg == ST_CALC) || (state_reg == ST_WAIT))
                       && a_idle && b_idle && slot_free;

    always_comb begin
        state_next       = state_reg;
        volume_next      = volume_reg;
        key_sound_next   = key_sound_reg;
        click_frame_next = click_frame_reg;
        phase_next       = phase_reg;
        amb_neg_next     = amb_neg_reg;
        clk_neg_next     = clk_neg_reg;
        m_tvalid_next    = m_tvalid_reg;
        mixed_next       = mixed_reg;
        clip_next        = clip_reg;

        // Register writes
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_VOLUME) begin
                volume_next = vol_wr;
            end else if (cfg_index == REG_KEY_SOUND) begin
                key_sound_next = key_sound_t'(cfg_data[1:0]);
            end
        end

        // Frame accept: update click state, latch signs
        if (in_xfer) begin
            phase_next   = p_inc;
            amb_neg_next = amb_neg;
            clk_neg_next = clk_neg;
            if (f_eff == '0) begin
                click_frame_next = '0;
            end else if (f_inc >= (FRAME_W+1)'(CLICK_FRAMES)) begin
                click_frame_next = '0;
            end else begin
                click_frame_next = f_inc[FRAME_W-1:0];
            end
        end

        // Output register
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (out_load) begin
            m_tvalid_next = 1'b1;
            if (sum_s > SW'(signed'(32767))) begin
                mixed_next = 16'sh7FFF;
                clip_next  = 1'b1;
            end else if (sum_s < -SW'(signed'(32768))) begin
                mixed_next = 16'sh8000;
                clip_next  = 1'b1;
            end else begin
                mixed_next = sum_s[SAMPLE_W-1:0];
                clip_next  = 1'b0;
            end
        end

        // Sequencer
        case (state_reg)
            ST_IDLE: begin
                if (lane_start) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (a_idle && b_idle) begin
                    state_next = slot_free ? ST_IDLE : ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            volume_reg      <= VOL_W'(VOL_RESET);
            key_sound_reg   <= KS_OFF;
            click_frame_reg <= '0;
            phase_reg       <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            volume_reg      <= volume_next;
            key_sound_reg   <= key_sound_next;
            click_frame_reg <= click_frame_next;
            phase_reg       <= phase_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        amb_neg_reg <= amb_neg_next;
        clk_neg_reg <= clk_neg_next;
        mixed_reg   <= mixed_next;
        clip_reg    <= clip_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = mixed_reg;
    assign m_tuser  = clip_reg;

`ifndef SYNTHESIS
    // Lanes are never busy while a new frame can be accepted
    a_lanes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (a_idle && b_idle))
        else $error("lane busy in idle state");

    // Click frame stays inside the click length
    a_frame_range: assert property (@(posedge aclk) disable iff (!aresetn)
        click_frame_reg < FRAME_W'(CLICK_FRAMES))
        else $error("click frame out of range");

    // Noise phase stays a residue
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg < PH_W'(NOISE_MOD))
        else $error("noise phase out of range");

    // Holding a finished mix only while the output register is full
    a_wait_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT) |-> m_tvalid_reg)
        else $error("waiting with empty output register");
`endif

endmodule

`default_nettype wire

>>> rtl/amck_serial_md.sv
`default_nettype none

// Unsigned (a * b) / DIV, truncated. Shift-add multiply one bit of b per
// cycle, then restoring divide one quotient bit per cycle.
module amck_serial_md #(
    parameter int AW  = 16,
    parameter int BW  = 7,
    parameter int DIV = 100
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [AW-1:0]     a_in,
    input  wire logic [BW-1:0]     b_in,
    output logic                   idle,
    output logic [AW+BW-1:0]       q
);

    localparam int PW = AW + BW;
    localparam int RW = $clog2(DIV) + 1;
    localparam int CW = $clog2(PW + 1);

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_MUL  = 3'b010,
        L_DIV  = 3'b100
    } lane_state_t;

    lane_state_t    state_reg, state_next;
    logic [PW-1:0]  mcand_reg, mcand_next;
    logic [BW-1:0]  mplier_reg, mplier_next;
    logic [PW-1:0]  acc_reg, acc_next;
    logic [RW-2:0]  rem_reg, rem_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    logic [RW-1:0]  rem_shift;
    logic [RW-1:0]  rem_sub;
    logic           rem_ge;

    // One restoring divide step
    assign rem_shift = {rem_reg, acc_reg[PW-1]};
    assign rem_ge    = (rem_shift >= RW'(DIV));
    assign rem_sub   = rem_shift - RW'(DIV);

    // Sequencer and datapath next values
    always_comb begin
        state_next  = state_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        case (state_reg)
            L_IDLE: begin
                if (start) begin
                    mcand_next  = PW'(a_in);
                    mplier_next = b_in;
                    acc_next    = '0;
                    rem_next    = '0;
                    cnt_next    = '0;
                    state_next  = L_MUL;
                end
            end
            L_MUL: begin
                if (mplier_reg[0]) begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[PW-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[BW-1:1]};
                if (cnt_reg == CW'(BW - 1)) begin
                    cnt_next   = '0;
                    state_next = L_DIV;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            L_DIV: begin
                rem_next = rem_ge ? rem_sub[RW-2:0] : rem_shift[RW-2:0];
                acc_next = {acc_reg[PW-2:0], rem_ge};
                if (cnt_reg == CW'(PW - 1)) begin
                    cnt_next   = '0;
                    state_next = L_IDLE;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            default: begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
    end

    assign idle = (state_reg == L_IDLE);
    assign q    = acc_reg;

endmodule

`default_nettype wire
